[design/hsv_zod_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_zod_pkg
// Shared types, constants and register map of the HSV zone occupancy detector.
// ----------------------------------------------------------------------------
package hsv_zod_pkg;

  localparam int unsigned NUM_ZONES_DEF    = 7;
  localparam int unsigned FRAME_WIDTH_DEF  = 640;
  localparam int unsigned FRAME_HEIGHT_DEF = 480;

  localparam int unsigned MAX_ZONES  = 7;
  localparam int unsigned CNT_W      = 13;
  localparam int unsigned DIM_W      = 13;
  localparam int unsigned APB_AW     = 5;
  localparam int unsigned APB_DW     = 32;

  localparam logic [8:0] ZONE_ROW_FIRST = 9'd100;
  localparam logic [8:0] ZONE_ROW_LAST  = 9'd200;
  localparam int unsigned ZONE_COL_BASE = 10;
  localparam int unsigned ZONE_COL_SPAN = 80;
  localparam int unsigned ZONE_PITCH    = 90;

  localparam logic [7:0]       HUE_LOW_RST   = 8'd0;
  localparam logic [7:0]       HUE_HIGH_RST  = 8'd179;
  localparam logic [7:0]       SAT_LOW_RST   = 8'd0;
  localparam logic [7:0]       SAT_HIGH_RST  = 8'd255;
  localparam logic [7:0]       VAL_LOW_RST   = 8'd0;
  localparam logic [7:0]       VAL_HIGH_RST  = 8'd255;
  localparam logic [CNT_W-1:0] THRESHOLD_RST = 13'd1500;

  typedef enum logic [2:0] {
    REG_HUE_LOW   = 3'd0,
    REG_HUE_HIGH  = 3'd1,
    REG_SAT_LOW   = 3'd2,
    REG_SAT_HIGH  = 3'd3,
    REG_VAL_LOW   = 3'd4,
    REG_VAL_HIGH  = 3'd5,
    REG_THRESHOLD = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [7:0]       hue_low;
    logic [7:0]       hue_high;
    logic [7:0]       sat_low;
    logic [7:0]       sat_high;
    logic [7:0]       val_low;
    logic [7:0]       val_high;
    logic [CNT_W-1:0] count_threshold;
  } cfg_t;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
    logic [8:0] row;
    logic [9:0] column;
    logic       frame_end;
  } pix_t;

endpackage

[design/hsv_zod_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_zod_cfg
// APB register file holding the colour bounds and the occupancy threshold.
// ----------------------------------------------------------------------------
module hsv_zod_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [hsv_zod_pkg::APB_AW-1:0] paddr,
  input  logic [hsv_zod_pkg::APB_DW-1:0] pwdata,
  output logic [hsv_zod_pkg::APB_DW-1:0] prdata,
  output logic                           pready,
  output hsv_zod_pkg::cfg_t              cfg_o
);
  import hsv_zod_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  reg_idx_e   idx;

  assign idx    = reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_HUE_LOW:   cfg_d.hue_low         = pwdata[7:0];
        REG_HUE_HIGH:  cfg_d.hue_high        = pwdata[7:0];
        REG_SAT_LOW:   cfg_d.sat_low         = pwdata[7:0];
        REG_SAT_HIGH:  cfg_d.sat_high        = pwdata[7:0];
        REG_VAL_LOW:   cfg_d.val_low         = pwdata[7:0];
        REG_VAL_HIGH:  cfg_d.val_high        = pwdata[7:0];
        REG_THRESHOLD: cfg_d.count_threshold = pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_HUE_LOW:   prdata = {24'd0, cfg_q.hue_low};
      REG_HUE_HIGH:  prdata = {24'd0, cfg_q.hue_high};
      REG_SAT_LOW:   prdata = {24'd0, cfg_q.sat_low};
      REG_SAT_HIGH:  prdata = {24'd0, cfg_q.sat_high};
      REG_VAL_LOW:   prdata = {24'd0, cfg_q.val_low};
      REG_VAL_HIGH:  prdata = {24'd0, cfg_q.val_high};
      REG_THRESHOLD: prdata = {{(APB_DW-CNT_W){1'b0}}, cfg_q.count_threshold};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hue_low         <= HUE_LOW_RST;
      cfg_q.hue_high        <= HUE_HIGH_RST;
      cfg_q.sat_low         <= SAT_LOW_RST;
      cfg_q.sat_high        <= SAT_HIGH_RST;
      cfg_q.val_low         <= VAL_LOW_RST;
      cfg_q.val_high        <= VAL_HIGH_RST;
      cfg_q.count_threshold <= THRESHOLD_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

[design/hsv_zod_match.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_zod_match
// Colour window test and zone decode; gives a one-hot zone hit per pixel.
// ----------------------------------------------------------------------------
module hsv_zod_match #(
  parameter int unsigned NUM_ZONES    = hsv_zod_pkg::NUM_ZONES_DEF,
  parameter int unsigned FRAME_WIDTH  = hsv_zod_pkg::FRAME_WIDTH_DEF,
  parameter int unsigned FRAME_HEIGHT = hsv_zod_pkg::FRAME_HEIGHT_DEF
) (
  input  hsv_zod_pkg::pix_t    pix_i,
  input  hsv_zod_pkg::cfg_t    cfg_i,
  output logic [NUM_ZONES-1:0] hit_o
);
  import hsv_zod_pkg::*;

  logic colour_ok;
  logic row_ok;
  logic in_frame;

  assign colour_ok = (pix_i.hue >= cfg_i.hue_low) && (pix_i.hue <= cfg_i.hue_high) &&
                     (pix_i.saturation >= cfg_i.sat_low) &&
                     (pix_i.saturation <= cfg_i.sat_high) &&
                     (pix_i.brightness >= cfg_i.val_low) &&
                     (pix_i.brightness <= cfg_i.val_high);

  assign in_frame = ({4'd0, pix_i.row} < DIM_W'(FRAME_HEIGHT)) &&
                    ({3'd0, pix_i.column} < DIM_W'(FRAME_WIDTH));

  assign row_ok = (pix_i.row >= ZONE_ROW_FIRST) && (pix_i.row <= ZONE_ROW_LAST);

  for (genvar n = 0; n < NUM_ZONES; n++) begin : g_zone
    localparam logic [9:0] ColLo = 10'(ZONE_COL_BASE + ZONE_PITCH * n);
    localparam logic [9:0] ColHi = 10'(ZONE_COL_BASE + ZONE_PITCH * n + ZONE_COL_SPAN);
    assign hit_o[n] = colour_ok && in_frame && row_ok &&
                      (pix_i.column >= ColLo) && (pix_i.column <= ColHi);
  end

endmodule

[design/hsv_zod_counters.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_zod_counters
// Per-zone saturating pixel counters with end-of-frame threshold flags.
// ----------------------------------------------------------------------------
module hsv_zod_counters #(
  parameter int unsigned NUM_ZONES = hsv_zod_pkg::NUM_ZONES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          frame_end_i,
  input  logic [NUM_ZONES-1:0]          hit_i,
  input  logic [hsv_zod_pkg::CNT_W-1:0] threshold_i,
  output logic [NUM_ZONES-1:0]          flags_o
);
  import hsv_zod_pkg::*;

  logic [CNT_W-1:0] cnt_q [NUM_ZONES];
  logic [CNT_W-1:0] cnt_d [NUM_ZONES];
  logic [CNT_W-1:0] cnt_inc [NUM_ZONES];

  for (genvar n = 0; n < NUM_ZONES; n++) begin : g_cnt
    // The flags see the count including the end-of-frame pixel itself.
    assign cnt_inc[n] = (hit_i[n] && (cnt_q[n] != {CNT_W{1'b1}})) ?
                        cnt_q[n] + CNT_W'(1) : cnt_q[n];
    assign flags_o[n] = cnt_inc[n] > threshold_i;

    always_comb begin
      cnt_d[n] = cnt_q[n];
      if (en_i) begin
        cnt_d[n] = frame_end_i ? '0 : cnt_inc[n];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cnt_q[n] <= '0;
      end else begin
        cnt_q[n] <= cnt_d[n];
      end
    end
  end

endmodule

[design/hsv_zone_occupancy_detector_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_zone_occupancy_detector_core
// Counts colour-matching pixels in seven column zones and reports, once per
// frame, which zones hold more matching pixels than the threshold.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  s_axis    in         one HSV pixel with row, column; tlast on frame end
//  m_axis    out        one zone flag word per frame
//  apb       in/out     colour bounds and count threshold
//
// One pixel is accepted per cycle unless the input stalls; a pixel is held in the
// input register and counted as it leaves it, and a frame's flag word is
// registered from the counts as its last pixel leaves the input register.
// Reset clears all zone counters and loads the default bounds and threshold.
// Only an end-of-frame pixel held in the input register can stall, and only
// while the previous flag word is still waiting on m_axis; the input waits
// behind it. Otherwise pixels pass regardless of m_axis.
// ----------------------------------------------------------------------------
module hsv_zone_occupancy_detector_core #(
  parameter int unsigned NUM_ZONES    = hsv_zod_pkg::NUM_ZONES_DEF,
  parameter int unsigned FRAME_WIDTH  = hsv_zod_pkg::FRAME_WIDTH_DEF,
  parameter int unsigned FRAME_HEIGHT = hsv_zod_pkg::FRAME_HEIGHT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // hue[7:0], saturation[15:8], brightness[23:16], row[32:24], column[42:33]
  input  logic [47:0]                    s_axis_tdata,
  input  logic                           s_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // zone_flags[6:0]
  output logic [7:0]                     m_axis_tdata,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [hsv_zod_pkg::APB_AW-1:0] paddr,
  input  logic [hsv_zod_pkg::APB_DW-1:0] pwdata,
  output logic [hsv_zod_pkg::APB_DW-1:0] prdata,
  output logic                           pready
);
  import hsv_zod_pkg::*;

  cfg_t                 cfg;
  pix_t                 pix_q;
  logic                 pix_valid_q, pix_valid_d;
  logic                 in_acc;
  logic                 pix_adv;
  logic                 out_free;
  logic [NUM_ZONES-1:0] hit;
  logic [NUM_ZONES-1:0] flags;
  logic                 out_valid_q, out_valid_d;
  logic [6:0]           out_flags_q;

  hsv_zod_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign out_free      = !out_valid_q || m_axis_tready;
  assign pix_adv       = pix_valid_q && (!pix_q.frame_end || out_free);
  assign s_axis_tready = !pix_valid_q || pix_adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    pix_valid_d = pix_valid_q;
    if (in_acc) begin
      pix_valid_d = 1'b1;
    end else if (pix_adv) begin
      pix_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_valid_q <= 1'b0;
    end else begin
      pix_valid_q <= pix_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pix_q.hue        <= s_axis_tdata[7:0];
      pix_q.saturation <= s_axis_tdata[15:8];
      pix_q.brightness <= s_axis_tdata[23:16];
      pix_q.row        <= s_axis_tdata[32:24];
      pix_q.column     <= s_axis_tdata[42:33];
      pix_q.frame_end  <= s_axis_tlast;
    end
  end

  hsv_zod_match #(
    .NUM_ZONES    (NUM_ZONES),
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_match (
    .pix_i (pix_q),
    .cfg_i (cfg),
    .hit_o (hit)
  );

  hsv_zod_counters #(
    .NUM_ZONES (NUM_ZONES)
  ) u_counters (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (pix_adv),
    .frame_end_i (pix_q.frame_end),
    .hit_i       (hit),
    .threshold_i (cfg.count_threshold),
    .flags_o     (flags)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (pix_adv && pix_q.frame_end) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_adv && pix_q.frame_end) begin
      out_flags_q <= 7'(flags);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_flags_q};

  a_frame_end_gives_result : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (pix_adv && pix_q.frame_end) |=> m_axis_tvalid
  ) else $error("end-of-frame item did not produce a flag word");

  a_no_overwrite : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (pix_valid_q && pix_q.frame_end && m_axis_tvalid && !m_axis_tready) |->
      (!pix_adv && !s_axis_tready)
  ) else $error("pending flag word would be overwritten");

  a_unused_flags_zero : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata >> NUM_ZONES) == 8'd0)
  ) else $error("flag bit set beyond the configured zone count");

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the HSV zone occupancy detector. Pixels are streamed
// with random gaps and output stalls. A shadow of the colour bounds and the
// zone counters predicts the flag word of every frame, and each flag word is
// compared with that prediction. The register port is checked by read-back.
// ----------------------------------------------------------------------------
module tb;
  import hsv_zod_pkg::*;

  localparam int HALF_PERIOD_NS = 6;
  localparam int TIMEOUT_NS     = 2_000_000;
  localparam int IDLE_PCT       = 26;
  localparam int DRAIN_CYCLES   = 6;
  localparam int HOLD_CYCLES    = 400;
  localparam int RANDOM_ITEMS   = 1450;
  localparam int unsigned CNT_MAX = (1 << CNT_W) - 1;
  localparam logic [APB_AW-1:0] ADDR_UNUSED = 5'd28;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // hue[7:0], saturation[15:8], brightness[23:16], row[32:24], column[42:33]
  logic [47:0]         s_axis_tdata  = '0;
  logic                s_axis_tlast  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // zone_flags[6:0]
  logic [7:0]          m_axis_tdata;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [APB_AW-1:0]   paddr         = '0;
  logic [APB_DW-1:0]   pwdata        = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  cfg_t             cfg_shadow;
  logic [CNT_W-1:0] zone_tally [MAX_ZONES];
  logic [6:0]       flags_expected_q [$];
  int               mismatches  = 0;
  int               pixels_sent = 0;
  bit               steady      = 1'b0;
  bit               rx_hold     = 1'b0;
  event             hold_start;

  hsv_zone_occupancy_detector_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    clk_i = 1'b0;
    #HALF_PERIOD_NS;
    clk_i = 1'b1;
    #HALF_PERIOD_NS;
  end

  initial begin
    #TIMEOUT_NS;
    $display("Mismatches found");
    $finish;
  end

  // Updates the zone counters for one accepted pixel; on the last pixel of a
  // frame the flag word is queued and the counters start again from zero.
  task automatic tally_pixel(input pix_t px);
    bit               hit;
    bit               counted;
    logic [6:0]       flags;
    int unsigned      lo;
    hit = px.hue >= cfg_shadow.hue_low && px.hue <= cfg_shadow.hue_high &&
          px.saturation >= cfg_shadow.sat_low && px.saturation <= cfg_shadow.sat_high &&
          px.brightness >= cfg_shadow.val_low && px.brightness <= cfg_shadow.val_high;
    if (hit && px.row < FRAME_HEIGHT_DEF && px.column < FRAME_WIDTH_DEF &&
        px.row >= ZONE_ROW_FIRST && px.row <= ZONE_ROW_LAST) begin
      counted = 1'b0;
      for (int n = 0; n < NUM_ZONES_DEF; n++) begin
        lo = ZONE_COL_BASE + ZONE_PITCH * n;
        if (!counted && px.column >= lo && px.column <= lo + ZONE_COL_SPAN) begin
          counted = 1'b1;
          if (zone_tally[n] < CNT_MAX) zone_tally[n] = zone_tally[n] + 1'b1;
        end
      end
    end
    if (px.frame_end) begin
      flags = '0;
      for (int n = 0; n < NUM_ZONES_DEF; n++) begin
        if (zone_tally[n] > cfg_shadow.count_threshold) flags[n] = 1'b1;
      end
      foreach (zone_tally[n]) zone_tally[n] = '0;
      flags_expected_q.push_back(flags);
    end
  endtask

  // Called and returns at a falling edge.
  task automatic send_pixel(input pix_t px);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, px.column, px.row, px.brightness, px.saturation, px.hue};
    s_axis_tlast  <= px.frame_end;
    do @(posedge clk_i); while (!s_axis_tready);
    tally_pixel(px);
    pixels_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (flags_expected_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  function automatic logic [APB_AW-1:0] reg_addr(input reg_idx_e r);
    return {r, 2'b00};
  endfunction

  task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr[1:0] == 2'b00) begin
      case (addr[4:2])
        REG_HUE_LOW:   cfg_shadow.hue_low         = data[7:0];
        REG_HUE_HIGH:  cfg_shadow.hue_high        = data[7:0];
        REG_SAT_LOW:   cfg_shadow.sat_low         = data[7:0];
        REG_SAT_HIGH:  cfg_shadow.sat_high        = data[7:0];
        REG_VAL_LOW:   cfg_shadow.val_low         = data[7:0];
        REG_VAL_HIGH:  cfg_shadow.val_high        = data[7:0];
        REG_THRESHOLD: cfg_shadow.count_threshold = data[CNT_W-1:0];
        default: ;
      endcase
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // Bits above the register's width carry random junk, which must be dropped.
  task automatic write_field(input reg_idx_e r, input int unsigned value);
    logic [APB_DW-1:0] data;
    data = $urandom();
    if (r == REG_THRESHOLD) data[CNT_W-1:0] = CNT_W'(value);
    else data[7:0] = 8'(value);
    apb_write(reg_addr(r), data);
  endtask

  task automatic apply_config(input int unsigned hl, input int unsigned hh,
                              input int unsigned sl, input int unsigned sh,
                              input int unsigned vl, input int unsigned vh,
                              input int unsigned thr);
    write_field(REG_HUE_LOW, hl);
    write_field(REG_HUE_HIGH, hh);
    write_field(REG_SAT_LOW, sl);
    write_field(REG_SAT_HIGH, sh);
    write_field(REG_VAL_LOW, vl);
    write_field(REG_VAL_HIGH, vh);
    write_field(REG_THRESHOLD, thr);
  endtask

  task automatic apb_read_check(input reg_idx_e r);
    logic [APB_DW-1:0] want;
    case (r)
      REG_HUE_LOW:   want = {24'b0, cfg_shadow.hue_low};
      REG_HUE_HIGH:  want = {24'b0, cfg_shadow.hue_high};
      REG_SAT_LOW:   want = {24'b0, cfg_shadow.sat_low};
      REG_SAT_HIGH:  want = {24'b0, cfg_shadow.sat_high};
      REG_VAL_LOW:   want = {24'b0, cfg_shadow.val_low};
      REG_VAL_HIGH:  want = {24'b0, cfg_shadow.val_high};
      default:       want = {{(APB_DW-CNT_W){1'b0}}, cfg_shadow.count_threshold};
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= reg_addr(r);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) begin
      $error("%s: expected %0d, actual %0d", r.name(), want, prdata);
      mismatches++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic read_back_all();
    for (int i = 0; i < 7; i++) apb_read_check(reg_idx_e'(i));
  endtask

  function automatic pix_t pixel_of(input int unsigned h, input int unsigned s,
                                    input int unsigned v, input int unsigned r,
                                    input int unsigned c, input bit last);
    pix_t p;
    p.hue        = 8'(h);
    p.saturation = 8'(s);
    p.brightness = 8'(v);
    p.row        = 9'(r);
    p.column     = 10'(c);
    p.frame_end  = last;
    return p;
  endfunction

  function automatic logic [7:0] channel_value(input logic [7:0] lo, input logic [7:0] hi);
    if ($urandom_range(0, 99) < 85) return 8'($urandom_range(lo, hi));
    return 8'($urandom_range(0, 255));
  endfunction

  // Mostly pixels inside a zone with channels mostly within the bounds, some on and
  // around the zone rows anywhere across the frame, and some with every field at random.
  function automatic pix_t random_pixel();
    pix_t        p;
    int unsigned kind;
    int unsigned lo;
    kind = $urandom_range(0, 99);
    p.hue        = channel_value(cfg_shadow.hue_low, cfg_shadow.hue_high);
    p.saturation = channel_value(cfg_shadow.sat_low, cfg_shadow.sat_high);
    p.brightness = channel_value(cfg_shadow.val_low, cfg_shadow.val_high);
    p.frame_end  = 1'b0;
    if (kind < 70) begin
      lo       = ZONE_COL_BASE + ZONE_PITCH * $urandom_range(0, NUM_ZONES_DEF - 1);
      p.row    = 9'($urandom_range(ZONE_ROW_FIRST, ZONE_ROW_LAST));
      p.column = 10'($urandom_range(lo, lo + ZONE_COL_SPAN));
    end else if (kind < 85) begin
      p.row    = 9'($urandom_range(90, 210));
      p.column = 10'($urandom_range(0, FRAME_WIDTH_DEF - 1));
    end else begin
      p.hue        = 8'($urandom_range(0, 255));
      p.saturation = 8'($urandom_range(0, 255));
      p.brightness = 8'($urandom_range(0, 255));
      p.row        = 9'($urandom_range(0, 511));
      p.column     = 10'($urandom_range(0, 1023));
    end
    return p;
  endfunction

  task automatic send_frame(input int len);
    pix_t p;
    for (int i = 0; i < len; i++) begin
      p = random_pixel();
      p.frame_end = (i == len - 1);
      send_pixel(p);
    end
  endtask

  task automatic random_bounds(output int unsigned lo, output int unsigned hi);
    case ($urandom_range(0, 9))
      0: begin lo = 0; hi = 255; end
      1: begin hi = $urandom_range(0, 200); lo = $urandom_range(hi + 1, 255); end
      2: begin lo = $urandom_range(0, 255); hi = lo; end
      default: begin lo = $urandom_range(0, 120); hi = $urandom_range(lo, 255); end
    endcase
  endtask

  task automatic random_config();
    int unsigned hl, hh, sl, sh, vl, vh, thr;
    random_bounds(hl, hh);
    random_bounds(sl, sh);
    random_bounds(vl, vh);
    case ($urandom_range(0, 9))
      0:       thr = 0;
      1:       thr = CNT_MAX;
      default: thr = $urandom_range(0, 5);
    endcase
    apply_config(hl, hh, sl, sh, vl, vh, thr);
    if ($urandom_range(0, 3) == 0) apb_write(ADDR_UNUSED, $urandom());
  endtask

  always @(negedge clk_i) begin
    if (rx_hold) m_axis_tready <= 1'b0;
    else if (steady) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Receiver hold-off, counted here so that the sender keeps offering pixels.
  initial forever begin
    @(hold_start);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  always @(posedge clk_i) begin : check_flags
    logic [6:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (flags_expected_q.size() == 0) begin
        $error("zone_flags: no flag word expected, actual %b", m_axis_tdata[6:0]);
        mismatches++;
      end else begin
        want = flags_expected_q.pop_front();
        if (m_axis_tdata[6:0] !== want) begin
          $error("zone_flags: expected %b, actual %b", want, m_axis_tdata[6:0]);
          mismatches++;
        end
        if (m_axis_tdata[7] !== 1'b0) begin
          $error("tdata padding: expected 0, actual %b", m_axis_tdata[7]);
          mismatches++;
        end
      end
    end
  end

  task automatic test_register_map();
    read_back_all();
    apply_config(255, 0, 255, 0, 255, 0, CNT_MAX);
    read_back_all();
    apply_config(0, 255, 0, 255, 0, 255, 0);
    read_back_all();
    // A write to the address past the last register must change nothing.
    apb_write(ADDR_UNUSED, '1);
    read_back_all();
  endtask

  task automatic test_directed();
    apply_config(20, 40, 50, 200, 60, 220, 0);
    send_pixel(pixel_of(20, 50, 60, 100, 10, 0));      // every low bound, zone 0 corner
    send_pixel(pixel_of(40, 200, 220, 200, 90, 0));    // every high bound, far corner
    send_pixel(pixel_of(19, 100, 100, 150, 50, 0));
    send_pixel(pixel_of(41, 100, 100, 150, 50, 0));
    send_pixel(pixel_of(30, 49, 100, 150, 50, 0));
    send_pixel(pixel_of(30, 201, 100, 150, 50, 0));
    send_pixel(pixel_of(30, 100, 59, 150, 50, 0));
    send_pixel(pixel_of(30, 100, 221, 150, 50, 0));
    send_pixel(pixel_of(30, 100, 100, 99, 50, 0));
    send_pixel(pixel_of(30, 100, 100, 201, 50, 0));
    send_pixel(pixel_of(30, 100, 100, 150, 9, 0));
    send_pixel(pixel_of(30, 100, 100, 150, 95, 0));    // gap between zones 0 and 1
    send_pixel(pixel_of(30, 100, 100, 150, 100, 0));
    send_pixel(pixel_of(30, 100, 100, 150, 630, 0));
    send_pixel(pixel_of(30, 100, 100, 150, 631, 0));
    send_pixel(pixel_of(30, 100, 100, 150, 700, 0));   // beyond the frame width
    send_pixel(pixel_of(30, 100, 100, 480, 50, 0));
    // The frame ends on a pixel outside the frame; the flag word still comes.
    send_pixel(pixel_of(30, 100, 100, 511, 1023, 1));
    drain_results();

    // Inverted hue bounds: nothing can match.
    apply_config(200, 10, 0, 255, 0, 255, 0);
    send_pixel(pixel_of(100, 100, 100, 150, 50, 1));
    drain_results();

    // Full bounds, hue above its usual range; the end pixel counts itself.
    apply_config(0, 255, 0, 255, 0, 255, 1);
    send_pixel(pixel_of(255, 255, 255, 150, 270, 0));
    send_pixel(pixel_of(0, 0, 0, 100, 190, 1));
    drain_results();
    write_field(REG_THRESHOLD, 2);
    send_pixel(pixel_of(255, 255, 255, 150, 270, 0));
    send_pixel(pixel_of(0, 0, 0, 100, 190, 1));
    drain_results();
  endtask

  task automatic test_backpressure();
    apply_config(0, 255, 0, 255, 0, 255, 1);
    steady = 1'b1;
    -> hold_start;
    repeat (30) send_frame($urandom_range(2, 5));
    steady = 1'b0;
    drain_results();
  endtask

  task automatic test_random();
    int start;
    int phase;
    start = pixels_sent;
    phase = 0;
    while (pixels_sent - start < RANDOM_ITEMS) begin
      random_config();
      steady = (phase == 3);
      repeat (8) send_frame($urandom_range(1, 48));
      drain_results();
      phase++;
    end
    steady = 1'b0;
  endtask

  initial begin
    cfg_shadow = {HUE_LOW_RST, HUE_HIGH_RST, SAT_LOW_RST, SAT_HIGH_RST,
                  VAL_LOW_RST, VAL_HIGH_RST, THRESHOLD_RST};
    foreach (zone_tally[n]) zone_tally[n] = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_register_map();
    test_directed();
    test_backpressure();
    test_random();
    drain_results();

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[filelist.f]
design/hsv_zod_pkg.sv
design/hsv_zod_cfg.sv
design/hsv_zod_match.sv
design/hsv_zod_counters.sv
design/hsv_zone_occupancy_detector_core.sv
tb/tb.sv
